>>> hdl/assert_macros.svh
// Assertion macros used by the checker module of the line parser.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge once reset has been released.
`define MLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define MLP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/mlp_pkg.sv
// Types and constants for the meter line parser.
// No dependencies; every other file but assert_macros.svh refers to it by scoped names.
package mlp_pkg;

  localparam int CHAR_W      = 7;
  localparam int LEN_W       = 4;
  localparam int SUM_W       = 8;
  localparam int FIRST_SLOTS = 8;
  localparam int LAST_SLOTS  = 4;
  localparam int VALUE_SLOTS = FIRST_SLOTS + LAST_SLOTS;
  localparam int NUM_NAMES   = 7;
  localparam int NAME_MAX    = 6;

  typedef logic [CHAR_W-1:0] char_t;

  localparam char_t CHAR_LF = 7'h0A;
  localparam char_t CHAR_CR = 7'h0D;
  localparam char_t CHAR_SP = 7'h20;

  localparam logic [SUM_W-1:0] CHECK_BIAS = 8'h20;
  localparam logic [5:0]       CHECK_MASK = 6'h3F;

  typedef enum logic [2:0] {
    FIELD_IDLE  = 3'd0,
    FIELD_LABEL = 3'd1,
    FIELD_VALUE = 3'd2,
    FIELD_CHECK = 3'd3,
    FIELD_EXTRA = 3'd4
  } field_pos_t;

  typedef enum logic [2:0] {
    CLASS_PTEC    = 3'd0,
    CLASS_IINST   = 3'd1,
    CLASS_PAPP    = 3'd2,
    CLASS_ISOUSC  = 3'd3,
    CLASS_HCHC    = 3'd4,
    CLASS_HCHP    = 3'd5,
    CLASS_BASE    = 3'd6,
    CLASS_UNKNOWN = 3'd7
  } label_class_t;

  typedef struct packed {
    logic store_label;
    logic store_value;
    logic add_check;
    logic emit;
  } step_ctrl_t;

  // Label names in priority order, padded with zero characters.
  localparam char_t NAME_TAB [NUM_NAMES][NAME_MAX] = '{
    '{7'h50, 7'h54, 7'h45, 7'h43, 7'h00, 7'h00},
    '{7'h49, 7'h49, 7'h4E, 7'h53, 7'h54, 7'h00},
    '{7'h50, 7'h41, 7'h50, 7'h50, 7'h00, 7'h00},
    '{7'h49, 7'h53, 7'h4F, 7'h55, 7'h53, 7'h43},
    '{7'h48, 7'h43, 7'h48, 7'h43, 7'h00, 7'h00},
    '{7'h48, 7'h43, 7'h48, 7'h50, 7'h00, 7'h00},
    '{7'h42, 7'h41, 7'h53, 7'h45, 7'h00, 7'h00}
  };

  localparam logic [2:0] NAME_LEN [NUM_NAMES] = '{
    3'd4, 3'd5, 3'd4, 3'd6, 3'd4, 3'd4, 3'd4
  };

endpackage

>>> hdl/meter_line_parser_unit.sv
// Top level of the meter line parser: field tracking, label and value buffers,
// label classification and the result register. Depends on mlp_pkg.
//
// Usage: one 7-bit character enters per request on the char channel
// (char_valid, char_stall, rx_char). A line feed opens a line, spaces move
// from label to value to checksum, and a carriage return inside a line
// produces one result on the result channel (result_valid, result_stall and
// the result fields). Every other character produces no result.
// A result is presented in the cycle after its carriage return is accepted.
// Throughput: one character per cycle unless a stalled result holds the char
// channel; the label comparators, the value packing and the checksum compare
// all sit between the line registers and the single result register.
// A stalled result holds in the result register, and the char channel is
// stalled for as long as a result waits with result_stall high, so no
// character is accepted until that result has been taken.
// Reset is synchronous: the block returns to outside any line with empty
// buffers and no pending result. It is ready in the first cycle after reset.
module meter_line_parser_unit #(
  parameter int LABEL_MAX = 8,
  parameter int VALUE_MAX = 12
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        char_valid,
  output logic                                        char_stall,
  input  logic [mlp_pkg::CHAR_W-1:0]                  rx_char,
  output logic                                        result_valid,
  input  logic                                        result_stall,
  output logic [2:0]                                  label_class,
  output logic [mlp_pkg::CHAR_W*mlp_pkg::FIRST_SLOTS-1:0] value_first_chars,
  output logic [mlp_pkg::CHAR_W*mlp_pkg::LAST_SLOTS-1:0]  value_last_chars,
  output logic [mlp_pkg::LEN_W-1:0]                   value_length,
  output logic                                        checksum_ok,
  output logic                                        overflow
);

  localparam int LCW = $clog2(LABEL_MAX + 1);
  localparam int LIW = $clog2(LABEL_MAX);
  localparam int VCW = $clog2(VALUE_MAX + 1);
  localparam int VIW = $clog2(VALUE_MAX);

  mlp_pkg::field_pos_t      field;
  mlp_pkg::field_pos_t      field_next;
  mlp_pkg::char_t           label_store [LABEL_MAX];
  logic [LCW-1:0]           label_count;
  mlp_pkg::char_t           value_store [VALUE_MAX];
  logic [VCW-1:0]           value_count;
  logic [mlp_pkg::SUM_W-1:0] running_sum;
  logic [mlp_pkg::SUM_W-1:0] received_check;
  logic                     dropped;

  logic                     accept;
  logic                     is_lf;
  mlp_pkg::step_ctrl_t      ctrl;
  logic                     label_full;
  logic                     value_full;
  logic [mlp_pkg::SUM_W-1:0] sum_with_space;
  logic [mlp_pkg::SUM_W-1:0] check_calc;
  logic [mlp_pkg::NUM_NAMES-1:0] name_hit;
  mlp_pkg::label_class_t    class_calc;
  logic [mlp_pkg::CHAR_W*mlp_pkg::VALUE_SLOTS-1:0] value_packed;

  assign char_stall = result_valid && result_stall;
  assign accept     = char_valid && !char_stall;
  assign is_lf      = (rx_char == mlp_pkg::CHAR_LF);
  assign label_full = (label_count == LCW'(LABEL_MAX));
  assign value_full = (value_count == VCW'(VALUE_MAX));

  always_comb begin
    field_next = field;
    if (is_lf) begin
      field_next = mlp_pkg::FIELD_LABEL;
    end else if (field != mlp_pkg::FIELD_IDLE) begin
      if (rx_char == mlp_pkg::CHAR_SP) begin
        case (field)
          mlp_pkg::FIELD_LABEL: field_next = mlp_pkg::FIELD_VALUE;
          mlp_pkg::FIELD_VALUE: field_next = mlp_pkg::FIELD_CHECK;
          mlp_pkg::FIELD_CHECK: field_next = mlp_pkg::FIELD_EXTRA;
          default:              field_next = field;
        endcase
      end else if (rx_char == mlp_pkg::CHAR_CR) begin
        field_next = mlp_pkg::FIELD_IDLE;
      end
    end
  end

  always_comb begin
    ctrl = '0;
    if (!is_lf && rx_char != mlp_pkg::CHAR_SP) begin
      if (rx_char == mlp_pkg::CHAR_CR) begin
        ctrl.emit = (field != mlp_pkg::FIELD_IDLE);
      end else begin
        case (field)
          mlp_pkg::FIELD_LABEL: ctrl.store_label = 1'b1;
          mlp_pkg::FIELD_VALUE: ctrl.store_value = 1'b1;
          mlp_pkg::FIELD_CHECK: ctrl.add_check   = 1'b1;
          default:              ctrl = '0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field          <= mlp_pkg::FIELD_IDLE;
      label_count    <= '0;
      value_count    <= '0;
      running_sum    <= '0;
      received_check <= '0;
      dropped        <= 1'b0;
    end else if (accept) begin
      field <= field_next;
      if (is_lf) begin
        label_count    <= '0;
        value_count    <= '0;
        running_sum    <= '0;
        received_check <= '0;
        dropped        <= 1'b0;
      end else begin
        if (ctrl.store_label || ctrl.store_value) begin
          running_sum <= running_sum + {1'b0, rx_char};
        end
        if (ctrl.store_label) begin
          if (label_full) begin
            dropped <= 1'b1;
          end else begin
            label_count <= label_count + 1'b1;
          end
        end
        if (ctrl.store_value) begin
          if (value_full) begin
            dropped <= 1'b1;
          end else begin
            value_count <= value_count + 1'b1;
          end
        end
        if (ctrl.add_check) begin
          received_check <= received_check + {1'b0, rx_char};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && ctrl.store_label && !label_full) begin
      label_store[label_count[LIW-1:0]] <= rx_char;
    end
    if (accept && ctrl.store_value && !value_full) begin
      value_store[value_count[VIW-1:0]] <= rx_char;
    end
  end

  always_comb begin
    logic [LABEL_MAX-1:0] start_hit;
    logic                 match;
    for (int k = 0; k < mlp_pkg::NUM_NAMES; k++) begin
      for (int s = 0; s < LABEL_MAX; s++) begin
        match = (int'(label_count) >= s + int'(mlp_pkg::NAME_LEN[k]));
        for (int i = 0; i < mlp_pkg::NAME_MAX; i++) begin
          if (i < int'(mlp_pkg::NAME_LEN[k]) && s + i < LABEL_MAX) begin
            if (label_store[s + i] != mlp_pkg::NAME_TAB[k][i]) begin
              match = 1'b0;
            end
          end
        end
        start_hit[s] = match;
      end
      name_hit[k] = |start_hit;
    end
  end

  always_comb begin
    class_calc = mlp_pkg::CLASS_UNKNOWN;
    for (int k = mlp_pkg::NUM_NAMES - 1; k >= 0; k--) begin
      if (name_hit[k]) begin
        class_calc = mlp_pkg::label_class_t'(3'(k));
      end
    end
  end

  for (genvar i = 0; i < mlp_pkg::VALUE_SLOTS; i++) begin : g_pack
    if (i < VALUE_MAX) begin : g_used
      assign value_packed[mlp_pkg::CHAR_W*i +: mlp_pkg::CHAR_W] =
        (value_count > VCW'(i)) ? value_store[i] : '0;
    end else begin : g_unused
      assign value_packed[mlp_pkg::CHAR_W*i +: mlp_pkg::CHAR_W] = '0;
    end
  end

  assign sum_with_space = running_sum + mlp_pkg::CHECK_BIAS;
  assign check_calc     = {2'b00, sum_with_space[5:0] & mlp_pkg::CHECK_MASK}
                          + mlp_pkg::CHECK_BIAS;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && ctrl.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && ctrl.emit) begin
      label_class       <= class_calc;
      value_first_chars <= value_packed[mlp_pkg::CHAR_W*mlp_pkg::FIRST_SLOTS-1:0];
      value_last_chars  <= value_packed[mlp_pkg::CHAR_W*mlp_pkg::VALUE_SLOTS-1:
                                        mlp_pkg::CHAR_W*mlp_pkg::FIRST_SLOTS];
      value_length      <= mlp_pkg::LEN_W'(value_count);
      checksum_ok       <= (check_calc == received_check);
      overflow          <= dropped;
    end
  end

endmodule

>>> hdl/mlp_checker.sv
// Port-level checks for the meter line parser, bound to its top level.
// Depends on assert_macros.svh and mlp_pkg.
`include "assert_macros.svh"

module mlp_checker (
  input logic                                            clk,
  input logic                                            rst,
  input logic                                            char_valid,
  input logic                                            char_stall,
  input logic [mlp_pkg::CHAR_W-1:0]                      rx_char,
  input logic                                            result_valid,
  input logic                                            result_stall,
  input logic [2:0]                                      label_class,
  input logic [mlp_pkg::CHAR_W*mlp_pkg::FIRST_SLOTS-1:0] value_first_chars,
  input logic [mlp_pkg::CHAR_W*mlp_pkg::LAST_SLOTS-1:0]  value_last_chars,
  input logic [mlp_pkg::LEN_W-1:0]                       value_length,
  input logic                                            checksum_ok,
  input logic                                            overflow
);

  `MLP_ASSERT(a_result_held, result_valid && result_stall |=> result_valid, "result dropped while stalled")
  `MLP_ASSERT(a_stall_passes_back, result_valid && result_stall |-> char_stall, "request taken while result blocked")
  `MLP_ASSERT(a_result_has_request, $rose(result_valid) |-> $past(char_valid && !char_stall), "result without request")
  `MLP_ASSERT(a_short_value_padded, result_valid && value_length <= 4'd8 |-> value_last_chars == '0, "short value has upper characters")
  `MLP_ASSERT_ALWAYS(a_reset_clears, rst |=> !result_valid, "result pending after reset")

endmodule

bind meter_line_parser_unit mlp_checker u_mlp_checker (.*);

>>> test/tb_top.sv
// Self-checking testbench for meter_line_parser_unit: sends meter lines and noise as
// character requests and checks every emitted line result against its own line parser.
// Depends on mlp_pkg and meter_line_parser_unit only.
module tb_top;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PRINT_LIMIT = 100;

  typedef struct packed {
    mlp_pkg::label_class_t cls;
    logic [55:0]  first_chars;
    logic [27:0]  last_chars;
    logic [3:0]   length;
    logic         check_ok;
    logic         dropped;
  } line_result_t;

  class meter_line_scoreboard;
    string               label_names [7];
    mlp_pkg::field_pos_t pos;
    mlp_pkg::char_t      label_buf [8];
    int                  label_cnt;
    mlp_pkg::char_t      value_buf [12];
    int                  value_cnt;
    logic [7:0]          line_sum;
    logic [7:0]          check_sum;
    logic                dropped;
    line_result_t        expected_lines [$];
    int                  errors;

    function new();
      label_names = '{"PTEC", "IINST", "PAPP", "ISOUSC", "HCHC", "HCHP", "BASE"};
      errors = 0;
      pos = mlp_pkg::FIELD_IDLE;
      clear_line();
    endfunction

    function void clear_line();
      foreach (label_buf[i]) label_buf[i] = '0;
      foreach (value_buf[i]) value_buf[i] = '0;
      label_cnt = 0;
      value_cnt = 0;
      line_sum = '0;
      check_sum = '0;
      dropped = 1'b0;
    endfunction

    // The first name, in priority order, found anywhere in the stored label wins.
    function mlp_pkg::label_class_t classify();
      string n;
      bit    hit;
      for (int k = 0; k < 7; k++) begin
        n = label_names[k];
        for (int s = 0; s + n.len() <= label_cnt; s++) begin
          hit = 1'b1;
          for (int i = 0; i < n.len(); i++)
            if (label_buf[s + i] != mlp_pkg::char_t'(n[i])) hit = 1'b0;
          if (hit) return mlp_pkg::label_class_t'(k);
        end
      end
      return mlp_pkg::CLASS_UNKNOWN;
    endfunction

    function void accept_char(mlp_pkg::char_t c);
      line_result_t r;
      logic [7:0]   total;
      logic [7:0]   calc;
      if (c == mlp_pkg::CHAR_LF) begin
        clear_line();
        pos = mlp_pkg::FIELD_LABEL;
        return;
      end
      if (pos == mlp_pkg::FIELD_IDLE) return;
      if (c == mlp_pkg::CHAR_SP) begin
        if (pos != mlp_pkg::FIELD_EXTRA) pos = mlp_pkg::field_pos_t'(pos + 3'd1);
        return;
      end
      if (c == mlp_pkg::CHAR_CR) begin
        r = '0;
        r.cls = classify();
        for (int i = 0; i < value_cnt; i++) begin
          if (i < 8) r.first_chars[7*i +: 7] = value_buf[i];
          else r.last_chars[7*(i-8) +: 7] = value_buf[i];
        end
        r.length = 4'(value_cnt);
        total = line_sum + 8'h20;
        calc = {2'b00, total[5:0]} + 8'h20;
        r.check_ok = (calc == check_sum);
        r.dropped = dropped;
        expected_lines.push_back(r);
        pos = mlp_pkg::FIELD_IDLE;
        return;
      end
      case (pos)
        mlp_pkg::FIELD_LABEL: begin
          line_sum = line_sum + {1'b0, c};
          if (label_cnt < 8) label_buf[label_cnt++] = c;
          else dropped = 1'b1;
        end
        mlp_pkg::FIELD_VALUE: begin
          line_sum = line_sum + {1'b0, c};
          if (value_cnt < 12) value_buf[value_cnt++] = c;
          else dropped = 1'b1;
        end
        mlp_pkg::FIELD_CHECK: check_sum = check_sum + {1'b0, c};
        default: ;
      endcase
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      if (errors <= PRINT_LIMIT)
        $display("mismatch %s: got %0h, expected %0h", what, got, want);
    endtask

    task check_line(line_result_t got);
      line_result_t want;
      if (expected_lines.size() == 0) begin
        report("unexpected result", got.length, 0);
        return;
      end
      want = expected_lines.pop_front();
      if (got.cls != want.cls) report("label_class", got.cls, want.cls);
      if (got.first_chars != want.first_chars)
        report("value_first_chars", got.first_chars, want.first_chars);
      if (got.last_chars != want.last_chars)
        report("value_last_chars", got.last_chars, want.last_chars);
      if (got.length != want.length) report("value_length", got.length, want.length);
      if (got.check_ok != want.check_ok) report("checksum_ok", got.check_ok, want.check_ok);
      if (got.dropped != want.dropped) report("overflow", got.dropped, want.dropped);
    endtask

    function int pending();
      return expected_lines.size();
    endfunction
  endclass

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           char_valid = 1'b0;
  logic           char_stall;
  mlp_pkg::char_t rx_char = '0;
  logic           result_valid;
  logic           result_stall = 1'b0;
  logic [2:0]     label_class;
  logic [55:0]    value_first_chars;
  logic [27:0]    value_last_chars;
  logic [3:0]     value_length;
  logic           checksum_ok;
  logic           overflow;

  meter_line_parser_unit u_dut (
    .clk               (clk),
    .rst               (rst),
    .char_valid        (char_valid),
    .char_stall        (char_stall),
    .rx_char           (rx_char),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .label_class       (label_class),
    .value_first_chars (value_first_chars),
    .value_last_chars  (value_last_chars),
    .value_length      (value_length),
    .checksum_ok       (checksum_ok),
    .overflow          (overflow)
  );

  meter_line_scoreboard sb = new();
  int             send_idle_pct = 0;
  int             recv_stall_pct = 0;
  int             chars_sent = 0;
  int             quiet_cycles = 0;
  mlp_pkg::char_t line_q [$];
  logic [7:0]     line_total;

  always #1 clk = ~clk;

  always @(posedge clk) result_stall <= ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk) begin
    line_result_t got;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        got.cls = mlp_pkg::label_class_t'(label_class);
        got.first_chars = value_first_chars;
        got.last_chars = value_last_chars;
        got.length = value_length;
        got.check_ok = checksum_ok;
        got.dropped = overflow;
        sb.check_line(got);
      end
      if (char_valid && !char_stall) sb.accept_char(rx_char);
      if ((char_valid && !char_stall) || (result_valid && !result_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[meter_line_parser_unit] ERROR");
        $finish;
      end
    end
  end

  task send_char(mlp_pkg::char_t c);
    if ($urandom_range(99) < send_idle_pct) begin
      char_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    char_valid <= 1'b1;
    rx_char <= c;
    do @(posedge clk); while (char_stall);
  endtask

  task send_queued();
    foreach (line_q[i]) send_char(line_q[i]);
    line_q.delete();
  endtask

  task drain_results();
    char_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic mlp_pkg::char_t plain_char();
    mlp_pkg::char_t c;
    do c = mlp_pkg::char_t'($urandom_range(127));
    while (c == mlp_pkg::CHAR_LF || c == mlp_pkg::CHAR_CR || c == mlp_pkg::CHAR_SP);
    return c;
  endfunction

  task push_summed(mlp_pkg::char_t c);
    line_q.push_back(c);
    line_total = line_total + {1'b0, c};
  endtask

  task push_name(string n);
    for (int i = 0; i < n.len(); i++) push_summed(mlp_pkg::char_t'(n[i]));
  endtask

  task push_plain(int n);
    repeat (n) push_summed(plain_char());
  endtask

  // Most lines are well formed with random labels, values and checksums; the rest
  // are noise with frequent line feeds, carriage returns and spaces.
  task send_line();
    logic [7:0] check_char;
    string      nm;
    int         pick;
    line_total = '0;
    if ($urandom_range(4) != 0) begin
      line_q.push_back(mlp_pkg::CHAR_LF);
      nm = sb.label_names[$urandom_range(6)];
      case ($urandom_range(9))
        0, 1, 2, 3, 4: push_name(nm);
        5: begin
          push_plain($urandom_range(1, 2));
          push_name(nm);
          push_plain($urandom_range(2));
        end
        6: begin
          push_name(nm);
          push_name(sb.label_names[$urandom_range(6)]);
        end
        7: push_name(nm.substr(0, nm.len() - 2));
        default: push_plain($urandom_range(10));
      endcase
      push_summed(mlp_pkg::CHAR_SP);
      push_plain(($urandom_range(9) == 0) ? $urandom_range(13, 15) : $urandom_range(12));
      line_q.push_back(mlp_pkg::CHAR_SP);
      check_char = {2'b00, line_total[5:0]} + 8'h20;
      pick = $urandom_range(19);
      if (pick < 15) line_q.push_back(check_char[6:0]);
      else if (pick < 17) line_q.push_back(plain_char());
      else if (pick > 17) begin
        line_q.push_back(plain_char());
        line_q.push_back(plain_char());
      end
      if ($urandom_range(9) == 0) begin
        line_q.push_back(mlp_pkg::CHAR_SP);
        line_q.push_back(plain_char());
        line_q.push_back(mlp_pkg::CHAR_SP);
        line_q.push_back(plain_char());
      end
      line_q.push_back(mlp_pkg::CHAR_CR);
    end else begin
      repeat ($urandom_range(3, 20)) begin
        pick = $urandom_range(19);
        if (pick < 3) line_q.push_back(mlp_pkg::CHAR_LF);
        else if (pick < 6) line_q.push_back(mlp_pkg::CHAR_CR);
        else if (pick < 9) line_q.push_back(mlp_pkg::CHAR_SP);
        else line_q.push_back(mlp_pkg::char_t'($urandom_range(127)));
      end
    end
    chars_sent += line_q.size();
    send_queued();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 25;
    recv_stall_pct = 46;

    // Ignored characters outside a line, a line restarted by a line feed, a line
    // with empty value and checksum fields, and an empty line.
    line_q = '{mlp_pkg::CHAR_CR, mlp_pkg::CHAR_SP, 7'h7F, mlp_pkg::CHAR_LF, 7'h00,
               7'h7F, mlp_pkg::CHAR_LF};
    line_total = '0;
    push_name("ISOUSC");
    line_q.push_back(mlp_pkg::CHAR_SP);
    line_q.push_back(mlp_pkg::CHAR_SP);
    line_q.push_back(mlp_pkg::CHAR_CR);
    line_q.push_back(mlp_pkg::CHAR_LF);
    line_q.push_back(mlp_pkg::CHAR_CR);
    send_queued();
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 46 : 0;
      recv_stall_pct = (phase == 0) ? 46 : (phase == 1) ? 25 : 0;
      while (chars_sent < 283 * (phase + 1)) begin
        send_line();
        if ($urandom_range(19) == 0) drain_results();
      end
      drain_results();
    end

    if (sb.errors == 0) $display("[meter_line_parser_unit] OK");
    else $display("[meter_line_parser_unit] ERROR");
    $finish;
  end
endmodule
